### rtl/wfc_pkg.sv
`timescale 1ns / 1ps
// Package for the word frequency counter: beat types, result kinds,
// character constants and the table control bundle. No dependencies.
package wfc_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_byte;
        logic       end_of_text;
        logic [9:0] read_index;
    } wfc_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  entry_index;
        logic [23:0] entry_count;
        logic        is_new;
        logic [31:0] total_words;
        logic [10:0] unique_words;
        logic [7:0]  out_char;
        logic        entry_valid;
        logic        last;
    } wfc_out_t;

    typedef struct packed {
        logic rd_en;
        logic row_we;
        logic cnt_we;
    } wfc_tbl_ctl_t;

    localparam logic       MODE_TEXT    = 1'b0;
    localparam logic       MODE_READ    = 1'b1;
    localparam logic [1:0] KIND_COUNTED = 2'd0;
    localparam logic [1:0] KIND_DROPPED = 2'd1;
    localparam logic [1:0] KIND_READOUT = 2'd2;

    localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_APOS    = 8'h27;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + (CH_LOWER_A - CH_UPPER_A);
        end
        return c;
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_ZERO && c <= CH_NINE) || (c == CH_APOS);
    endfunction

endpackage

### rtl/wfc_word_buf.sv
`timescale 1ns / 1ps
// Pending word assembly: folds case, classifies bytes and appends word
// characters up to MAX_WORD_LEN of them. Depends on wfc_pkg.
module wfc_word_buf
    import wfc_pkg::*;
#(
    parameter int MAX_WORD_LEN = 32,
    parameter int LEN_W        = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  logic [7:0]                char_in,
    input  logic                      clear,
    output logic                      word_char,
    output logic [LEN_W-1:0]          word_len,
    output logic [8*MAX_WORD_LEN-1:0] word_flat
);

    logic [7:0]       buf_reg [MAX_WORD_LEN];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [7:0]       folded;
    logic             append;

    assign folded    = fold_char(char_in);
    assign word_char = is_word_char(folded);
    assign append    = push && word_char && (len_reg < LEN_W'(MAX_WORD_LEN));
    assign word_len  = len_reg;

    always_comb begin
        len_next = len_reg;
        if (clear) begin
            len_next = '0;
        end else if (append) begin
            len_next = len_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (append && len_reg == LEN_W'(i)) begin
                buf_reg[i] <= folded;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            word_flat[8*i +: 8] = buf_reg[i];
        end
    end

endmodule

### rtl/wfc_table.sv
`timescale 1ns / 1ps
// Word table storage: one memory of rows (length and characters) and one
// of counts, both with a registered read port. Depends on wfc_pkg.
module wfc_table
    import wfc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int IDX_W         = 10,
    parameter int ROW_W         = 262
) (
    input  logic              aclk,
    input  wfc_tbl_ctl_t      ctl,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [ROW_W-1:0]  wr_row,
    input  logic [23:0]       wr_cnt,
    output logic [ROW_W-1:0]  rd_row,
    output logic [23:0]       rd_cnt
);

    logic [ROW_W-1:0] row_mem [TABLE_ENTRIES];
    logic [23:0]      cnt_mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (ctl.row_we) begin
            row_mem[wr_addr] <= wr_row;
        end
        if (ctl.rd_en) begin
            rd_row <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.cnt_we) begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (ctl.rd_en) begin
            rd_cnt <= cnt_mem[rd_addr];
        end
    end

endmodule

### rtl/word_frequency_counter.sv
`timescale 1ns / 1ps
// Word frequency counter top level: control sequencer, result register.
// Depends on wfc_pkg, wfc_word_buf and wfc_table.
//
// Usage: text bytes enter on the s_ channel (mode 0), one byte per beat.
// A byte that ends a non-empty word, or a word byte with end_of_text set,
// starts a search of the table; that beat yields one result beat on the
// m_ channel with last set. Bytes that finish no word yield nothing and
// are taken in consecutive cycles. A mode 1 beat reads one entry back as
// one result beat per stored character, or one beat for an unused entry.
// Timing: entries are compared one per cycle through the row memory read
// port; a matched word stops at its entry, and a new or dropped word walks
// all entries in use. A readout gives one beat per cycle for as long as the
// receiver takes them.
// While a word is searched or an entry is read out, s_ready is low; it
// returns as soon as the result is loaded into the output register, so
// the next beat is taken while it waits. When the receiver stalls, the
// output register holds the beat and the sequencer waits for it. Reset
// empties the table and zeroes the totals; no clearing pass is needed
// since the entry count bounds every read.
module word_frequency_counter
    import wfc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MAX_WORD_LEN  = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  wfc_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output wfc_out_t m_data
);

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int ROW_W  = LEN_W + 8 * MAX_WORD_LEN;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CMP     = 6'b000010,
        ST_INSERT  = 6'b000100,
        ST_RD_WAIT = 6'b001000,
        ST_RDOUT   = 6'b010000,
        ST_EMIT    = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [USED_W-1:0] srch_reg, srch_next;
    logic [31:0]       total_reg, total_next;
    logic [9:0]        ridx_reg, ridx_next;
    logic [LEN_W-1:0]  chidx_reg, chidx_next;
    wfc_out_t          res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    wfc_out_t          m_data_reg, m_data_next;

    logic                      accept;
    logic                      slot_free;
    logic                      word_char;
    logic [LEN_W-1:0]          word_len;
    logic [8*MAX_WORD_LEN-1:0] word_flat;
    logic                      word_clear;
    logic                      push;
    wfc_tbl_ctl_t              tbl_ctl;
    logic [IDX_W-1:0]          rd_addr, wr_addr;
    logic [ROW_W-1:0]          rd_row;
    logic [23:0]               rd_cnt;
    logic [23:0]               wr_cnt;
    logic                      match;
    logic [LEN_W-1:0]          row_len;
    logic [7:0]                row_char;
    logic [USED_W+9:0]         ridx_w;
    logic [USED_W+9:0]         used_w;
    logic [USED_W-1:0]         srch_inc;

    function automatic logic [10:0] to_unique(input logic [USED_W-1:0] v);
        logic [USED_W+10:0] t;
        t = (USED_W + 11)'(v);
        return t[10:0];
    endfunction

    function automatic logic [9:0] to_index(input logic [USED_W-1:0] v);
        logic [USED_W+9:0] t;
        t = (USED_W + 10)'(v);
        return t[9:0];
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign push      = accept && (s_data.mode == MODE_TEXT);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign ridx_w    = (USED_W + 10)'(s_data.read_index);
    assign used_w    = (USED_W + 10)'(used_reg);
    assign srch_inc  = srch_reg + 1'b1;
    assign row_len   = rd_row[LEN_W-1:0];

    wfc_word_buf #(
        .MAX_WORD_LEN(MAX_WORD_LEN),
        .LEN_W       (LEN_W)
    ) u_word (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .char_in  (s_data.char_byte),
        .clear    (word_clear),
        .word_char(word_char),
        .word_len (word_len),
        .word_flat(word_flat)
    );

    wfc_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IDX_W        (IDX_W),
        .ROW_W        (ROW_W)
    ) u_table (
        .aclk   (aclk),
        .ctl    (tbl_ctl),
        .rd_addr(rd_addr),
        .wr_addr(wr_addr),
        .wr_row ({word_flat, word_len}),
        .wr_cnt (wr_cnt),
        .rd_row (rd_row),
        .rd_cnt (rd_cnt)
    );

    always_comb begin
        match = (row_len == word_len);
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (LEN_W'(i) < word_len &&
                rd_row[LEN_W + 8*i +: 8] != word_flat[8*i +: 8]) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        row_char = '0;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (chidx_reg == LEN_W'(i)) begin
                row_char = rd_row[LEN_W + 8*i +: 8];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        used_next    = used_reg;
        srch_next    = srch_reg;
        total_next   = total_reg;
        ridx_next    = ridx_reg;
        chidx_next   = chidx_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        tbl_ctl      = '0;
        rd_addr      = '0;
        wr_addr      = srch_reg[IDX_W-1:0];
        wr_cnt       = (rd_cnt < COUNT_MAX) ? rd_cnt + 1'b1 : COUNT_MAX;
        word_clear   = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ridx_next = s_data.read_index;
                    if (s_data.mode == MODE_READ) begin
                        if (ridx_w < used_w) begin
                            tbl_ctl.rd_en = 1'b1;
                            rd_addr       = ridx_w[IDX_W-1:0];
                            state_next    = ST_RD_WAIT;
                        end else begin
                            res_next              = '0;
                            res_next.kind         = KIND_READOUT;
                            res_next.entry_index  = s_data.read_index;
                            res_next.total_words  = total_reg;
                            res_next.unique_words = to_unique(used_reg);
                            res_next.last         = 1'b1;
                            state_next            = ST_EMIT;
                        end
                    end else if (word_char ? s_data.end_of_text : (word_len != '0)) begin
                        total_next = (total_reg < TOTAL_MAX) ? total_reg + 1'b1 : TOTAL_MAX;
                        srch_next  = '0;
                        if (used_reg == '0) begin
                            state_next = ST_INSERT;
                        end else begin
                            tbl_ctl.rd_en = 1'b1;
                            state_next    = ST_CMP;
                        end
                    end
                end
            end
            ST_CMP: begin
                if (match) begin
                    tbl_ctl.cnt_we        = 1'b1;
                    word_clear            = 1'b1;
                    res_next              = '0;
                    res_next.kind         = KIND_COUNTED;
                    res_next.entry_index  = to_index(srch_reg);
                    res_next.entry_count  = wr_cnt;
                    res_next.total_words  = total_reg;
                    res_next.unique_words = to_unique(used_reg);
                    res_next.last         = 1'b1;
                    state_next            = ST_EMIT;
                end else begin
                    srch_next = srch_inc;
                    if (srch_inc == used_reg) begin
                        state_next = ST_INSERT;
                    end else begin
                        tbl_ctl.rd_en = 1'b1;
                        rd_addr       = srch_inc[IDX_W-1:0];
                    end
                end
            end
            ST_INSERT: begin
                word_clear            = 1'b1;
                res_next              = '0;
                res_next.total_words  = total_reg;
                res_next.last         = 1'b1;
                if (used_reg >= USED_W'(TABLE_ENTRIES)) begin
                    res_next.kind         = KIND_DROPPED;
                    res_next.unique_words = to_unique(used_reg);
                end else begin
                    tbl_ctl.row_we        = 1'b1;
                    tbl_ctl.cnt_we        = 1'b1;
                    wr_addr               = used_reg[IDX_W-1:0];
                    wr_cnt                = 24'd1;
                    used_next             = used_reg + 1'b1;
                    res_next.kind         = KIND_COUNTED;
                    res_next.entry_index  = to_index(used_reg);
                    res_next.entry_count  = 24'd1;
                    res_next.is_new       = 1'b1;
                    res_next.unique_words = to_unique(used_next);
                end
                state_next = ST_EMIT;
            end
            ST_RD_WAIT: begin
                chidx_next = '0;
                state_next = ST_RDOUT;
            end
            ST_RDOUT: begin
                if (slot_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next              = '0;
                    m_data_next.kind         = KIND_READOUT;
                    m_data_next.entry_index  = ridx_reg;
                    m_data_next.entry_count  = rd_cnt;
                    m_data_next.total_words  = total_reg;
                    m_data_next.unique_words = to_unique(used_reg);
                    m_data_next.out_char     = row_char;
                    m_data_next.entry_valid  = 1'b1;
                    m_data_next.last         = (chidx_reg + 1'b1 == row_len);
                    chidx_next               = chidx_reg + 1'b1;
                    if (chidx_reg + 1'b1 == row_len) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        srch_reg   <= srch_next;
        ridx_reg   <= ridx_next;
        chidx_reg  <= chidx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_W'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (srch_reg < used_reg))
        else $error("search index beyond entries in use");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_DROPPED) |-> (used_reg == USED_W'(TABLE_ENTRIES)))
        else $error("word dropped while table has room");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INSERT) |=> (state_reg == ST_EMIT && word_len == '0))
        else $error("pending word not cleared after insert");

endmodule

### verif/tb_word_frequency_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for word_frequency_counter: drives byte and readout
// beats, predicts the result beats with its own table model, and compares.
// Depends on wfc_pkg and the word_frequency_counter RTL.
module tb_word_frequency_counter;
    import wfc_pkg::*;

    localparam int NUM_ENTRIES = 1024;
    localparam int WORD_MAX    = 32;
    localparam int STALL_LIMIT = 200000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    wfc_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wfc_out_t m_data;

    word_frequency_counter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    wfc_in_t  pending_beats[$];
    wfc_out_t expected_beats[$];

    logic [7:0]  cur_word[WORD_MAX];
    int          cur_len;
    logic [7:0]  tbl_chars[NUM_ENTRIES][WORD_MAX];
    int          tbl_len[NUM_ENTRIES];
    logic [23:0] tbl_count[NUM_ENTRIES];
    int          tbl_used;
    logic [31:0] word_sum;

    int  errors = 0;
    bit  calm = 1'b0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  idle_cycles = 0;

    function automatic wfc_out_t make_beat(logic [1:0] k, int idx, logic [23:0] cnt,
                                           logic nw, logic [7:0] ch, logic vld,
                                           logic lst);
        wfc_out_t r;
        r.kind = k;
        r.entry_index = idx[9:0];
        r.entry_count = cnt;
        r.is_new = nw;
        r.total_words = word_sum;
        r.unique_words = tbl_used[10:0];
        r.out_char = ch;
        r.entry_valid = vld;
        r.last = lst;
        return r;
    endfunction

    task automatic close_word();
        int  e;
        int  hit;
        bit  same;
        hit = -1;
        if (word_sum != TOTAL_MAX) word_sum++;
        for (e = 0; e < tbl_used && hit < 0; e++) begin
            same = (tbl_len[e] == cur_len);
            for (int i = 0; i < cur_len && same; i++)
                if (tbl_chars[e][i] != cur_word[i]) same = 1'b0;
            if (same) hit = e;
        end
        if (hit >= 0) begin
            if (tbl_count[hit] != COUNT_MAX) tbl_count[hit]++;
            expected_beats.push_back(make_beat(KIND_COUNTED, hit, tbl_count[hit],
                                               1'b0, 8'h00, 1'b0, 1'b1));
        end else if (tbl_used >= NUM_ENTRIES) begin
            expected_beats.push_back(make_beat(KIND_DROPPED, 0, 24'd0, 1'b0, 8'h00,
                                               1'b0, 1'b1));
        end else begin
            for (int i = 0; i < cur_len; i++) tbl_chars[tbl_used][i] = cur_word[i];
            tbl_len[tbl_used] = cur_len;
            tbl_count[tbl_used] = 24'd1;
            tbl_used++;
            expected_beats.push_back(make_beat(KIND_COUNTED, tbl_used - 1, 24'd1,
                                               1'b1, 8'h00, 1'b0, 1'b1));
        end
        cur_len = 0;
    endtask

    task automatic predict_counts(wfc_in_t b);
        logic [7:0] c;
        int         ri;
        if (b.mode == MODE_READ) begin
            ri = b.read_index;
            if (ri >= tbl_used || tbl_len[ri] == 0) begin
                expected_beats.push_back(make_beat(KIND_READOUT, ri, 24'd0, 1'b0,
                                                   8'h00, 1'b0, 1'b1));
            end else begin
                for (int i = 0; i < tbl_len[ri]; i++)
                    expected_beats.push_back(make_beat(KIND_READOUT, ri, tbl_count[ri],
                        1'b0, tbl_chars[ri][i], 1'b1, i == tbl_len[ri] - 1));
            end
            return;
        end
        c = b.char_byte;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + 8'd32;
        if ((c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_ZERO && c <= CH_NINE) ||
            c == CH_APOS) begin
            if (cur_len < WORD_MAX) begin
                cur_word[cur_len] = c;
                cur_len++;
            end
            if (b.end_of_text) close_word();
        end else if (cur_len > 0) begin
            close_word();
        end
    endtask

    task automatic add_beat(logic md, logic [7:0] ch, logic eot, logic [9:0] ri);
        wfc_in_t b;
        b.mode = md;
        b.char_byte = ch;
        b.end_of_text = eot;
        b.read_index = ri;
        pending_beats.push_back(b);
    endtask

    task automatic add_text(string s, logic eot_last);
        for (int i = 0; i < s.len(); i++)
            add_beat(MODE_TEXT, s[i], eot_last && i == s.len() - 1,
                     10'($urandom_range(0, 1023)));
    endtask

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 9))
            0: return 8'h27;
            1, 2: return 8'($urandom_range(8'h30, 8'h39));
            3, 4: return 8'($urandom_range(8'h41, 8'h5A));
            default: return 8'($urandom_range(8'h61, 8'h66));
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_counts(s_data);
        end
        if (aresetn && (!s_valid || s_ready)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                s_data <= pending_beats.pop_front();
                s_valid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        wfc_out_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, m_data);
                errors++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (m_data !== exp_b) begin
                    $display("%0t: result mismatch, expected %p, actual %p",
                             $time, exp_b, m_data);
                    errors++;
                end
            end
        end
        if (aresetn) begin
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 11);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int n;
        int wl;
        cur_len = 0;
        tbl_used = 0;
        word_sum = 0;
        for (int e = 0; e < NUM_ENTRIES; e++) tbl_len[e] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        add_beat(MODE_READ, 8'hFF, 1'b1, 10'd0);
        add_text(" Hello, hello", 1'b1);
        add_text("It's 9Z!", 1'b0);
        add_beat(MODE_TEXT, 8'h80, 1'b0, 10'h3FF);
        add_beat(MODE_TEXT, 8'hFF, 1'b1, 10'h000);
        add_text("abcdefghijklmnopqrstuvwxyz0123456789", 1'b1);
        add_beat(MODE_READ, 8'h41, 1'b0, 10'd3);
        add_beat(MODE_READ, 8'h00, 1'b0, 10'd0);
        add_beat(MODE_READ, 8'h00, 1'b0, 10'h3FF);
        add_beat(MODE_TEXT, 8'h27, 1'b0, 10'd0);
        add_beat(MODE_TEXT, 8'h2E, 1'b0, 10'd0);

        n = 0;
        while (n < 115) begin
            if ($urandom_range(0, 5) == 0) begin
                add_beat(MODE_READ, 8'($urandom), 1'($urandom),
                         ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                         10'($urandom_range(0, 40)));
                n++;
            end else begin
                wl = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 40) :
                     $urandom_range(1, 3);
                for (int i = 0; i < wl; i++) begin
                    add_beat(MODE_TEXT, rand_word_char(),
                             i == wl - 1 && $urandom_range(0, 4) == 0, 10'($urandom));
                    n++;
                end
                add_beat(MODE_TEXT, ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h20,
                         1'($urandom), 10'($urandom));
                n++;
            end
            if (n > 80) calm = 1'b1;
        end

        wait (pending_beats.size() == 0 && !s_valid);
        wait (expected_beats.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
